@@ hdl/ofrb_pkg.sv @@
// ----------------------------------------------------------------------------
// ofrb_pkg
// Types, constants and helper functions for the overwriting frame ring buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package ofrb_pkg;

   localparam int MAX_CHANNELS = 8;
   localparam int MAX_FRAMES   = 4096;

   localparam int CH_W    = $clog2(MAX_CHANNELS);
   localparam int SLOT_W  = $clog2(MAX_FRAMES);
   localparam int ADDR_W  = SLOT_W + CH_W;
   localparam int DEPTH   = MAX_FRAMES * MAX_CHANNELS;

   localparam int CCNT_W  = 4;
   localparam int CAP_W   = 13;
   localparam int SAMP_W  = 32;
   localparam int BLK_W   = 32;
   localparam int IDX_W   = 64;
   localparam int OVR_W   = 32;
   localparam int CSR_W   = 13;

   localparam logic REG_CHANNEL_COUNT = 1'b0;
   localparam logic REG_CAPACITY      = 1'b1;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WR_EVAL,
      ST_WR_EVAL2,
      ST_WR_MOD,
      ST_WR_COMMIT,
      ST_RD_EVAL,
      ST_RD_CHK,
      ST_RD_MOD,
      ST_RD_EMIT
   } state_type;

   function automatic logic [CCNT_W-1:0] eff_channels(input logic [CCNT_W-1:0] cc);
      logic [CCNT_W-1:0] r;
      r = cc;
      if (cc == '0) r = CCNT_W'(1);
      else if (cc > CCNT_W'(MAX_CHANNELS)) r = CCNT_W'(MAX_CHANNELS);
      return r;
   endfunction

   function automatic logic [CAP_W-1:0] eff_capacity(input logic [CAP_W-1:0] cf);
      logic [CAP_W-1:0] r;
      r = cf;
      if (cf == '0) r = CAP_W'(1);
      else if (cf > CAP_W'(MAX_FRAMES)) r = CAP_W'(MAX_FRAMES);
      return r;
   endfunction

endpackage

`default_nettype wire

@@ hdl/ofrb_ram.sv @@
// ----------------------------------------------------------------------------
// ofrb_ram
// Generic simple dual-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ofrb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ hdl/ofrb_mod_unit.sv @@
// ----------------------------------------------------------------------------
// ofrb_mod_unit
// Bit-serial 64-bit by 13-bit remainder, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ofrb_mod_unit (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [ofrb_pkg::IDX_W-1:0]   dividend,
   input  wire logic [ofrb_pkg::CAP_W-1:0]   divisor,
   output logic                              done,
   output logic      [ofrb_pkg::CAP_W-1:0]   remainder
);

   localparam int CNT_W = $clog2(ofrb_pkg::IDX_W);

   logic                         active_ff, active_in;
   logic                         done_ff, done_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [ofrb_pkg::IDX_W-1:0]   dvd_ff, dvd_in;
   logic [ofrb_pkg::CAP_W-1:0]   dvs_ff, dvs_in;
   logic [ofrb_pkg::CAP_W-1:0]   rem_ff, rem_in;
   logic [ofrb_pkg::CAP_W:0]     shifted;

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      dvd_in    = dvd_ff;
      dvs_in    = dvs_ff;
      rem_in    = rem_ff;
      shifted   = {rem_ff, dvd_ff[ofrb_pkg::IDX_W-1]};
      if (start) begin
         active_in = 1'b1;
         cnt_in    = '0;
         dvd_in    = dividend;
         dvs_in    = divisor;
         rem_in    = '0;
      end else if (active_ff) begin
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = ofrb_pkg::CAP_W'(shifted - {1'b0, dvs_ff});
         end else begin
            rem_in = ofrb_pkg::CAP_W'(shifted);
         end
         dvd_in = {dvd_ff[ofrb_pkg::IDX_W-2:0], 1'b0};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(ofrb_pkg::IDX_W - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

@@ hdl/overwriting_frame_ring_buffer_core.sv @@
// ----------------------------------------------------------------------------
// overwriting_frame_ring_buffer_core
// Overwriting ring of interleaved audio frames with a lapped reader.
//
// Channel   Handshake                 Payload
// request   start / busy              req_type, req_sample_bits, req_block_frames,
//                                     req_block_last, req_reader_index
// response  rsp_valid (1 cycle)       rsp_out_sample .. rsp_last
// csr       csr_we                    csr_index, csr_wdata
//
// Write transaction: evaluate, then the serial remainder unit when the sample
// is stored, then commit. Read transaction: lap check, availability check, the serial
// remainder unit (skipped for zero fill), then one response per channel.
// Responses stream one per cycle; the receiver cannot stall them.
// Synchronous reset; the sample RAM is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module overwriting_frame_ring_buffer_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic                              req_type,
   input  wire logic [ofrb_pkg::SAMP_W-1:0]       req_sample_bits,
   input  wire logic [ofrb_pkg::BLK_W-1:0]        req_block_frames,
   input  wire logic                              req_block_last,
   input  wire logic [ofrb_pkg::IDX_W-1:0]        req_reader_index,
   output logic                                   rsp_valid,
   output logic      [ofrb_pkg::SAMP_W-1:0]       rsp_out_sample,
   output logic                                   rsp_copied,
   output logic                                   rsp_lapped,
   output logic      [ofrb_pkg::IDX_W-1:0]        rsp_next_reader_index,
   output logic      [ofrb_pkg::OVR_W-1:0]        rsp_overrun_total,
   output logic                                   rsp_last,
   input  wire logic                              csr_we,
   input  wire logic                              csr_index,
   input  wire logic [ofrb_pkg::CSR_W-1:0]        csr_wdata
);

   ofrb_pkg::state_type state_ff, state_in;

   logic [ofrb_pkg::CCNT_W-1:0]  chcnt_ff;
   logic [ofrb_pkg::CAP_W-1:0]   cap_ff;

   logic [ofrb_pkg::IDX_W-1:0]   fwi_ff, fwi_in;
   logic [ofrb_pkg::OVR_W-1:0]   ovr_ff, ovr_in;
   logic [ofrb_pkg::CH_W-1:0]    chpos_ff, chpos_in;
   logic [ofrb_pkg::BLK_W-1:0]   bfp_ff, bfp_in;

   logic [ofrb_pkg::SAMP_W-1:0]  samp_ff, samp_in;
   logic [ofrb_pkg::BLK_W-1:0]   frames_ff, frames_in;
   logic                         blast_ff, blast_in;
   logic [ofrb_pkg::IDX_W-1:0]   rd_ff, rd_in;
   logic [ofrb_pkg::BLK_W-1:0]   drop_ff, drop_in;
   logic                         big_ff, big_in;
   logic                         inblk_ff, inblk_in;
   logic                         store_ff, store_in;
   logic [ofrb_pkg::CAP_W-1:0]   off_ff, off_in;
   logic [ofrb_pkg::SLOT_W-1:0]  slot_ff, slot_in;
   logic [ofrb_pkg::CH_W-1:0]    k_ff, k_in;
   logic                         lap_ff, lap_in;
   logic                         avail_ff, avail_in;
   logic [ofrb_pkg::IDX_W-1:0]   next_ff, next_in;
   logic                         rvalid_ff, rvalid_in;
   logic                         rlast_ff, rlast_in;

   logic [ofrb_pkg::CCNT_W-1:0]  ch_eff;
   logic [ofrb_pkg::CAP_W-1:0]   cap_eff;
   logic [ofrb_pkg::IDX_W-1:0]   cap64;
   logic [ofrb_pkg::BLK_W-1:0]   cap32;
   logic [ofrb_pkg::CAP_W:0]     slot_sum;

   logic                         mod_start, mod_done;
   logic [ofrb_pkg::IDX_W-1:0]   mod_dividend;
   logic [ofrb_pkg::CAP_W-1:0]   mod_rem;

   logic                         ram_we, ram_re;
   logic [ofrb_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
   logic [ofrb_pkg::SAMP_W-1:0]  ram_rdata;

   assign ch_eff  = ofrb_pkg::eff_channels(chcnt_ff);
   assign cap_eff = ofrb_pkg::eff_capacity(cap_ff);
   assign cap64   = ofrb_pkg::IDX_W'(cap_eff);
   assign cap32   = ofrb_pkg::BLK_W'(cap_eff);
   assign busy    = (state_ff != ofrb_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         chcnt_ff <= ofrb_pkg::CCNT_W'(2);
         cap_ff   <= ofrb_pkg::CAP_W'(ofrb_pkg::MAX_FRAMES);
      end else if (csr_we) begin
         unique case (csr_index)
            ofrb_pkg::REG_CHANNEL_COUNT: chcnt_ff <= csr_wdata[ofrb_pkg::CCNT_W-1:0];
            ofrb_pkg::REG_CAPACITY:      cap_ff   <= csr_wdata[ofrb_pkg::CAP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ofrb_pkg::ST_IDLE: begin
            if (start) begin
               state_in = (req_type == ofrb_pkg::REQ_READ) ? ofrb_pkg::ST_RD_EVAL
                                                           : ofrb_pkg::ST_WR_EVAL;
            end
         end
         ofrb_pkg::ST_WR_EVAL:   state_in = ofrb_pkg::ST_WR_EVAL2;
         ofrb_pkg::ST_WR_EVAL2: begin
            state_in = store_in ? ofrb_pkg::ST_WR_MOD : ofrb_pkg::ST_WR_COMMIT;
         end
         ofrb_pkg::ST_WR_MOD: begin
            if (mod_done) state_in = ofrb_pkg::ST_WR_COMMIT;
         end
         ofrb_pkg::ST_WR_COMMIT: state_in = ofrb_pkg::ST_IDLE;
         ofrb_pkg::ST_RD_EVAL:   state_in = ofrb_pkg::ST_RD_CHK;
         ofrb_pkg::ST_RD_CHK: begin
            state_in = avail_in ? ofrb_pkg::ST_RD_MOD : ofrb_pkg::ST_RD_EMIT;
         end
         ofrb_pkg::ST_RD_MOD: begin
            if (mod_done) state_in = ofrb_pkg::ST_RD_EMIT;
         end
         ofrb_pkg::ST_RD_EMIT: begin
            if (rlast_in) state_in = ofrb_pkg::ST_IDLE;
         end
         default: state_in = ofrb_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      fwi_in    = fwi_ff;
      ovr_in    = ovr_ff;
      chpos_in  = chpos_ff;
      bfp_in    = bfp_ff;
      samp_in   = samp_ff;
      frames_in = frames_ff;
      blast_in  = blast_ff;
      rd_in     = rd_ff;
      drop_in   = drop_ff;
      big_in    = big_ff;
      inblk_in  = inblk_ff;
      store_in  = store_ff;
      off_in    = off_ff;
      slot_in   = slot_ff;
      k_in      = k_ff;
      lap_in    = lap_ff;
      avail_in  = avail_ff;
      next_in   = next_ff;
      rvalid_in = 1'b0;
      rlast_in  = 1'b0;
      mod_start    = 1'b0;
      mod_dividend = fwi_ff;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      slot_sum  = {1'b0, mod_rem} + {1'b0, off_ff};
      if (slot_sum >= {1'b0, cap_eff}) slot_sum = slot_sum - {1'b0, cap_eff};
      ram_waddr = {slot_sum[ofrb_pkg::SLOT_W-1:0], chpos_ff};
      ram_raddr = {slot_ff, k_ff};
      unique case (state_ff)
         ofrb_pkg::ST_IDLE: begin
            if (start) begin
               samp_in   = req_sample_bits;
               frames_in = req_block_frames;
               blast_in  = req_block_last;
               rd_in     = req_reader_index;
            end
         end
         ofrb_pkg::ST_WR_EVAL: begin
            if (ofrb_pkg::CCNT_W'(chpos_ff) >= ch_eff) chpos_in = '0;
            big_in   = frames_ff > cap32;
            drop_in  = (frames_ff > cap32) ? frames_ff - cap32 : '0;
            inblk_in = bfp_ff < frames_ff;
         end
         ofrb_pkg::ST_WR_EVAL2: begin
            store_in = inblk_ff && (bfp_ff >= drop_ff);
            off_in   = ofrb_pkg::CAP_W'(bfp_ff - drop_ff);
            mod_start = store_in;
         end
         ofrb_pkg::ST_WR_MOD: ;
         ofrb_pkg::ST_WR_COMMIT: begin
            ram_we = store_ff;
            if (inblk_ff) begin
               if (ofrb_pkg::CCNT_W'(chpos_ff) + ofrb_pkg::CCNT_W'(1) >= ch_eff) begin
                  chpos_in = '0;
                  bfp_in   = bfp_ff + ofrb_pkg::BLK_W'(1);
               end else begin
                  chpos_in = chpos_ff + ofrb_pkg::CH_W'(1);
               end
            end
            if (blast_ff) begin
               fwi_in   = fwi_ff + ofrb_pkg::IDX_W'(big_ff ? cap32 : frames_ff);
               if (big_ff) ovr_in = ovr_ff + ofrb_pkg::OVR_W'(1);
               chpos_in = '0;
               bfp_in   = '0;
            end
         end
         ofrb_pkg::ST_RD_EVAL: begin
            lap_in = (fwi_ff > cap64) && ((fwi_ff - cap64) > rd_ff);
            if (lap_in) begin
               rd_in  = fwi_ff - cap64;
               ovr_in = ovr_ff + ofrb_pkg::OVR_W'(1);
            end
         end
         ofrb_pkg::ST_RD_CHK: begin
            avail_in     = fwi_ff > rd_ff;
            next_in      = avail_in ? rd_ff + ofrb_pkg::IDX_W'(1) : rd_ff;
            k_in         = '0;
            mod_start    = avail_in;
            mod_dividend = rd_ff;
         end
         ofrb_pkg::ST_RD_MOD: begin
            slot_in = mod_rem[ofrb_pkg::SLOT_W-1:0];
         end
         ofrb_pkg::ST_RD_EMIT: begin
            ram_re    = 1'b1;
            rvalid_in = 1'b1;
            rlast_in  = (ofrb_pkg::CCNT_W'(k_ff) + ofrb_pkg::CCNT_W'(1)) == ch_eff;
            k_in      = k_ff + ofrb_pkg::CH_W'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ofrb_pkg::ST_IDLE;
         fwi_ff    <= '0;
         ovr_ff    <= '0;
         chpos_ff  <= '0;
         bfp_ff    <= '0;
         rvalid_ff <= 1'b0;
         rlast_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fwi_ff    <= fwi_in;
         ovr_ff    <= ovr_in;
         chpos_ff  <= chpos_in;
         bfp_ff    <= bfp_in;
         rvalid_ff <= rvalid_in;
         rlast_ff  <= rlast_in;
      end
      samp_ff   <= samp_in;
      frames_ff <= frames_in;
      blast_ff  <= blast_in;
      rd_ff     <= rd_in;
      drop_ff   <= drop_in;
      big_ff    <= big_in;
      inblk_ff  <= inblk_in;
      store_ff  <= store_in;
      off_ff    <= off_in;
      slot_ff   <= slot_in;
      k_ff      <= k_in;
      lap_ff    <= lap_in;
      avail_ff  <= avail_in;
      next_ff   <= next_in;
   end

   ofrb_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_dividend),
      .divisor   (cap_eff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   ofrb_ram #(
      .WIDTH (ofrb_pkg::SAMP_W),
      .DEPTH (ofrb_pkg::DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (samp_ff),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rsp_valid             = rvalid_ff;
   assign rsp_out_sample        = avail_ff ? ram_rdata : '0;
   assign rsp_copied            = avail_ff;
   assign rsp_lapped            = lap_ff;
   assign rsp_next_reader_index = next_ff;
   assign rsp_overrun_total     = ovr_ff;
   assign rsp_last              = rlast_ff;

`ifndef SYNTHESIS
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ofrb_pkg::ST_RD_EMIT))
      else $error("response without emit cycle");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");
   a_zero_fill: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_copied) |-> (rsp_out_sample == '0))
      else $error("zero fill carries data");
   a_no_write_on_read: assert property (@(posedge clock) disable iff (reset)
      ram_re |-> !ram_we)
      else $error("RAM read and write in one cycle");
`endif

endmodule

`default_nettype wire
